[src/pscsc_pkg.sv]
// Shared types and constants for the power-to-speed event update block.
`default_nettype none
package pscsc_pkg;

  localparam int unsigned CIRC_W   = 12;
  localparam int unsigned AERO_W   = 20;
  localparam int unsigned ROLL_W   = 24;
  localparam int unsigned THR_W    = 14;
  localparam int unsigned POWER_W  = 12;
  localparam int unsigned SIM_W    = 14;
  localparam int unsigned CAD_W    = 8;
  localparam int unsigned SPEED_W  = 14;
  localparam int unsigned TIME_W   = 16;

  // Register indexes on the configuration channel.
  localparam logic [7:0] REG_CIRC = 8'd0;
  localparam logic [7:0] REG_AERO = 8'd1;
  localparam logic [7:0] REG_ROLL = 8'd2;
  localparam logic [7:0] REG_THR  = 8'd3;

  // Velocity in Q24 m/s stays below 30*2^24, so 29 bits.
  localparam int unsigned VEL_W  = 29;
  localparam int unsigned V2_W   = 34;
  localparam int unsigned V3_W   = 39;
  localparam int unsigned ACC_W  = 60;
  localparam int unsigned MULA_W = 39;
  localparam int unsigned MULB_W = 29;
  localparam int unsigned PROD_W = MULA_W + MULB_W;

endpackage
`default_nettype wire

[src/power_to_speed_csc_event_update_core.sv]
// Top level: power or simulated speed to wheel and crank event updates.
//
// Usage: one input item per update tick on s_tvalid/s_tready/s_tdata; one
// result item per input on m_tvalid/m_tready/m_tdata. Registers are written
// on cfg_valid/cfg_ready (ready only while idle) with cfg_index and cfg_data.
// Sequence: the power estimate runs BISECT_STEPS bisection steps, each
// through the velocity, square, cube, aero, roll and compare states (four
// products on one shared multiplier), then the wheel division and the
// crank division, each NW = max(31, BISECT_STEPS+22) quotient bits after a
// load state. The simulated path skips the bisection; a zero-cadence or
// standing tick skips the matching division.
// One item at a time: s_tready is high only in the idle state.
// The result sits in an output register until taken; a stalled receiver
// holds the block in its final state before the counters update.
// Reset clears counters, event times and the sequencer and loads the
// default register values.
`default_nettype none
module power_to_speed_csc_event_update_core
  import pscsc_pkg::*;
#(
  parameter int unsigned BISECT_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // power_watts, simulated_speed, cadence_rpm
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,  // wheel_rev_total, wheel_event_time,
                                     // crank_rev_total, crank_event_time, speed_used
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned S  = BISECT_STEPS;
  localparam int unsigned NW = (S + 22 > 31) ? S + 22 : 31;
  localparam int unsigned DW = (S + 15 > 24) ? S + 15 : 24;
  localparam int unsigned CW = $clog2(S + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VEL  = 4'd1;
  localparam logic [3:0] ST_SQ   = 4'd2;
  localparam logic [3:0] ST_CUBE = 4'd3;
  localparam logic [3:0] ST_AERO = 4'd4;
  localparam logic [3:0] ST_ROLL = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_WLD  = 4'd7;
  localparam logic [3:0] ST_WWT  = 4'd8;
  localparam logic [3:0] ST_CLD  = 4'd9;
  localparam logic [3:0] ST_CWT  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  logic [3:0] state;

  logic [CIRC_W-1:0] circ;
  logic [AERO_W-1:0] aero;
  logic [ROLL_W-1:0] roll;
  logic [THR_W-1:0]  thr;

  logic [POWER_W-1:0] power;
  logic [SIM_W-1:0]   sim;
  logic [CAD_W-1:0]   cad;
  logic               est;
  logic               moving;

  logic [S:0]       lo;
  logic [S:0]       hi;
  logic [CW-1:0]    cnt;
  logic [VEL_W-1:0] v;
  logic [V2_W-1:0]  v2;
  logic [V3_W-1:0]  v3;
  logic [ACC_W-1:0] acc;

  logic [SPEED_W-1:0] speed;
  logic [TIME_W-1:0]  wperiod;
  logic [TIME_W-1:0]  cperiod;

  logic [31:0]       wheel_count;
  logic [TIME_W-1:0] wheel_time;
  logic [15:0]       crank_count;
  logic [TIME_W-1:0] crank_time;

  // Bisection arithmetic.
  logic [S+1:0]       lohi;
  logic [S-1:0]       mid;
  logic [S+4:0]       mid30;
  logic [S+28:0]      vwide;
  logic [S:0]         odd;
  logic [S+13:0]      odd_speed;
  logic [ACC_W+1:0]   target;

  assign lohi      = {1'b0, lo} + {1'b0, hi};
  assign mid       = lohi[S:1];
  assign mid30     = ({5'd0, mid} << 5) - ({5'd0, mid} << 1);
  assign vwide     = {mid30, 24'd0};
  assign odd       = {lo[S-1:0], 1'b1};
  assign odd_speed = {13'd0, odd} * (S+14)'(5400);
  assign target    = {{(ACC_W + 2 - POWER_W - 40){1'b0}}, power, 40'd0};

  // Shared multiplier.
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  always_comb begin
    mul_a = MULA_W'(v);
    mul_b = v;
    case (state)
      ST_CUBE: begin
        mul_a = MULA_W'(v2);
        mul_b = v;
      end
      ST_AERO: begin
        mul_a = v3;
        mul_b = MULB_W'(aero);
      end
      ST_ROLL: begin
        mul_a = MULA_W'(v);
        mul_b = MULB_W'(roll);
      end
      default: begin
        mul_a = MULA_W'(v);
        mul_b = v;
      end
    endcase
  end

  assign prod = {{MULB_W{1'b0}}, mul_a} * {{MULA_W{1'b0}}, mul_b};

  // Shared divider.
  logic              div_start;
  logic              div_done;
  logic [NW-1:0]     dnum;
  logic [DW-1:0]     dden;
  logic [TIME_W-1:0] dquo;

  assign div_start = (state == ST_WLD) || (state == ST_CLD);

  always_comb begin
    dnum = NW'(16'd61440);
    dden = DW'(cad);
    if (state == ST_WLD) begin
      if (est) begin
        dnum = NW'({circ, {(S + 10){1'b0}}});
        dden = DW'({14'd0, odd} * (S+15)'(15000));
      end else begin
        dnum = NW'({19'd0, circ} * 31'd368640);
        dden = DW'({10'd0, sim} * 24'd1000);
      end
    end
  end

  pscsc_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (dden),
    .done  (div_done),
    .quo   (dquo)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  logic out_load;
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  logic [31:0]       wheel_count_next;
  logic [TIME_W-1:0] wheel_time_next;
  logic [15:0]       crank_count_next;
  logic [TIME_W-1:0] crank_time_next;

  always_comb begin
    wheel_count_next = wheel_count;
    wheel_time_next  = wheel_time;
    crank_count_next = crank_count;
    crank_time_next  = crank_time;
    if (moving) begin
      wheel_count_next = wheel_count + 32'd1;
      wheel_time_next  = wheel_time + wperiod;
    end
    if (cad != '0) begin
      crank_count_next = crank_count + 16'd1;
      crank_time_next  = crank_time + cperiod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      circ <= CIRC_W'(2127);
      aero <= AERO_W'(20070);
      roll <= ROLL_W'(231367);
      thr  <= THR_W'(500);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CIRC: circ <= cfg_data[CIRC_W-1:0];
        REG_AERO: aero <= cfg_data[AERO_W-1:0];
        REG_ROLL: roll <= cfg_data[ROLL_W-1:0];
        REG_THR:  thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      wheel_count <= '0;
      wheel_time  <= '0;
      crank_count <= '0;
      crank_time  <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tdata[25:12] > thr) begin
              state <= ST_WLD;
            end else if (s_tdata[11:0] != '0) begin
              state <= ST_VEL;
            end else if (s_tdata[33:26] != '0) begin
              state <= ST_CLD;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_VEL:  state <= ST_SQ;
        ST_SQ:   state <= ST_CUBE;
        ST_CUBE: state <= ST_AERO;
        ST_AERO: state <= ST_ROLL;
        ST_ROLL: state <= ST_CMP;
        ST_CMP:  state <= (cnt == CW'(S - 1)) ? ST_WLD : ST_VEL;
        ST_WLD:  state <= ST_WWT;
        ST_WWT: begin
          if (div_done) state <= (cad != '0) ? ST_CLD : ST_FIN;
        end
        ST_CLD:  state <= ST_CWT;
        ST_CWT: begin
          if (div_done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state       <= ST_IDLE;
            wheel_count <= wheel_count_next;
            wheel_time  <= wheel_time_next;
            crank_count <= crank_count_next;
            crank_time  <= crank_time_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        power   <= s_tdata[11:0];
        sim     <= s_tdata[25:12];
        cad     <= s_tdata[33:26];
        est     <= !(s_tdata[25:12] > thr);
        moving  <= (s_tdata[25:12] > thr) || (s_tdata[11:0] != '0);
        speed   <= (s_tdata[25:12] > thr) ? s_tdata[25:12] : '0;
        lo      <= '0;
        hi      <= {1'b1, {S{1'b0}}};
        cnt     <= '0;
        wperiod <= '0;
        cperiod <= '0;
      end
      ST_VEL:  v  <= vwide[S+28:S];
      ST_SQ:   v2 <= prod[V2_W+23:24];
      ST_CUBE: v3 <= prod[V3_W+23:24];
      ST_AERO: acc <= prod[ACC_W-1:0];
      ST_ROLL: acc <= acc + prod[ACC_W-1:0];
      ST_CMP: begin
        // Raise the lower bound while the power need falls short.
        if ({2'b00, acc} < target) lo <= {1'b0, mid};
        else hi <= {1'b0, mid};
        cnt <= cnt + 1'b1;
      end
      ST_WLD: begin
        if (est) speed <= odd_speed[S+13:S];
      end
      ST_WWT: begin
        if (div_done) wperiod <= dquo;
      end
      ST_CWT: begin
        if (div_done) cperiod <= dquo;
      end
      ST_FIN: begin
        if (out_load) begin
          m_tdata <= {2'b00, speed, crank_time_next, crank_count_next,
                      wheel_time_next, wheel_count_next};
        end
      end
      default: ;
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_VEL |-> hi > lo) else $error("bisection bounds crossed");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(wheel_count) && $stable(crank_count))
    else $error("counter moved without a result");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_WWT || state == ST_CWT)
    else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

[src/pscsc_div.sv]
// Restoring divider, one quotient bit per cycle, low 16 quotient bits kept.
`default_nettype none
module pscsc_div
  import pscsc_pkg::*;
#(
  parameter int unsigned NW = 46,
  parameter int unsigned DW = 39
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NW-1:0]   num,
  input  wire logic [DW-1:0]   den,
  output logic                 done,
  output logic [TIME_W-1:0]    quo
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_sh;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem[DW-1:0], num_sh[NW-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NW-2:0], 1'b0};
      rem    <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo    <= {quo[TIME_W-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider restarted while busy");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the power-to-speed wheel and crank event update block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import pscsc_pkg::*;
();

  localparam int unsigned STEPS = 24;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_STALL = 1500;
  localparam logic [7:0] REG_UNUSED = 8'd9;

  typedef struct packed {
    logic [CAD_W-1:0]   cadence;
    logic [SIM_W-1:0]   sim_speed;
    logic [POWER_W-1:0] power;
  } tick_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [15:0]        crank_time;
    logic [15:0]        crank_revs;
    logic [15:0]        wheel_time;
    logic [31:0]        wheel_revs;
  } events_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of registers and counters
  logic [CIRC_W-1:0] circ_mm;
  logic [AERO_W-1:0] aero_q16;
  logic [ROLL_W-1:0] roll_q16;
  logic [THR_W-1:0]  sim_thresh;
  logic [31:0] wheel_revs;
  logic [15:0] wheel_time;
  logic [15:0] crank_revs;
  logic [15:0] crank_time;

  tick_t   tick_queue[$];
  events_t expected_events[$];
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned stall_left = 0;
  logic stall_kick = 1'b0;
  logic no_idle = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  power_to_speed_csc_event_update_core #(.BISECT_STEPS(STEPS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bisection of aero*v^3 + roll*v = power; returns the final low bound.
  function automatic logic [63:0] solve_speed(input logic [63:0] power);
    logic [63:0] lo, hi, target, mid, v, v2, v3, need;
    lo = 0;
    hi = 64'd1 << STEPS;
    target = power << 40;
    for (int i = 0; i < STEPS; i++) begin
      mid = (lo + hi) >> 1;
      v = ((mid * 30) << 24) >> STEPS;
      v2 = (v * v) >> 24;
      v3 = (v2 * v) >> 24;
      need = 64'(aero_q16) * v3 + 64'(roll_q16) * v;
      if (need < target) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic events_t update_events(input tick_t t);
    logic [63:0] speed, period, odd, circ;
    events_t r;
    speed = 0;
    period = 0;
    circ = 64'(circ_mm);
    if (t.sim_speed > sim_thresh) begin
      speed = 64'(t.sim_speed);
      period = (1024 * circ * 360) / (1000 * 64'(t.sim_speed));
      wheel_revs = wheel_revs + 32'd1;
      wheel_time = wheel_time + period[15:0];
    end else if (t.power != 0) begin
      odd = 2 * solve_speed(64'(t.power)) + 1;
      speed = (odd * 5400) >> STEPS;
      period = ((1024 * circ) << STEPS) / (15000 * odd);
      wheel_revs = wheel_revs + 32'd1;
      wheel_time = wheel_time + period[15:0];
    end
    if (t.cadence != 0) begin
      crank_revs = crank_revs + 16'd1;
      crank_time = crank_time + 16'(61440 / int'(t.cadence));
    end
    r.wheel_revs = wheel_revs;
    r.wheel_time = wheel_time;
    r.crank_revs = crank_revs;
    r.crank_time = crank_time;
    r.speed = speed[SPEED_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Sender: hold an item until taken, then wait its drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_events.push_back(update_events(tick_t'(s_tdata[33:0])));
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (tick_queue.size() > 0) begin
        s_tdata <= {6'b0, tick_queue.pop_front()};
        s_tvalid <= 1'b1;
        send_gap <= draw_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_kick) stall_left <= LONG_STALL;
    else if (stall_left > 0) stall_left <= stall_left - 1;
  end

  // Receiver: check each taken item, then back off for a drawn gap.
  always @(posedge clk) begin
    events_t got, want;
    int unsigned g;
    cycles <= cycles + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = events_t'(m_tdata[93:0]);
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: wheel %0d/%0d t %0d/%0d crank %0d/%0d t %0d/%0d spd %0d/%0d",
                       want.wheel_revs, got.wheel_revs, want.wheel_time, got.wheel_time,
                       want.crank_revs, got.crank_revs, want.crank_time, got.crank_time,
                       want.speed, got.speed);
          end
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        g = draw_gap();
        take_gap <= (g == 0) ? 0 : g - 1;
        m_tready <= (g == 0);
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_CIRC: circ_mm = value[CIRC_W-1:0];
      REG_AERO: aero_q16 = value[AERO_W-1:0];
      REG_ROLL: roll_q16 = value[ROLL_W-1:0];
      REG_THR:  sim_thresh = value[THR_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (tick_queue.size() != 0 || s_tvalid || expected_events.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_tick(input int unsigned p, input int unsigned s, input int unsigned c);
    tick_t t;
    t.power = POWER_W'(p);
    t.sim_speed = SIM_W'(s);
    t.cadence = CAD_W'(c);
    tick_queue.push_back(t);
  endtask

  // Random ticks, a third with zero simulated speed, some around and above the threshold.
  task automatic add_random(input int unsigned n);
    int unsigned p, s, c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: s = $urandom_range(0, 16383);
        1: s = sim_thresh + $urandom_range(0, 2);
        2, 3: s = $urandom_range(0, 10000);
        default: s = 0;
      endcase
      p = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 4095);
      c = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
      add_tick(p, s, c);
    end
  endtask

  task automatic load_regs(input int unsigned c, input int unsigned a,
                           input int unsigned r, input int unsigned t);
    write_reg(REG_CIRC, c);
    write_reg(REG_AERO, a);
    write_reg(REG_ROLL, r);
    write_reg(REG_THR, t);
  endtask

  initial begin
    circ_mm = CIRC_W'(2127);
    aero_q16 = AERO_W'(20070);
    roll_q16 = ROLL_W'(231367);
    sim_thresh = THR_W'(500);
    wheel_revs = '0;
    wheel_time = '0;
    crank_revs = '0;
    crank_time = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    add_tick(0, 0, 0);
    add_tick(4095, 0, 255);
    add_tick(1, 0, 1);
    add_tick(0, 500, 2);
    add_tick(0, 501, 0);
    add_tick(200, 500, 90);
    add_tick(0, 10000, 60);
    add_tick(0, 10800, 120);
    add_tick(0, 16383, 255);
    add_tick(4095, 16383, 0);
    add_tick(12'haaa, 14'h1555, 8'h55);
    add_tick(12'h555, 14'h2aaa, 8'haa);
    add_tick(250, 0, 85);
    drain();

    // ignored index and masked values
    write_reg(REG_UNUSED, 32'hffff_ffff);
    load_regs(32'hffff_f000, 32'hfff0_0000, 32'hff00_0000, 32'hffff_c000);
    add_tick(4095, 0, 255);
    add_tick(1, 0, 3);
    add_tick(0, 1, 7);
    add_random(150);
    drain();

    load_regs(4095, 1048575, 16777215, 16383);
    add_tick(4095, 16383, 255);
    add_tick(1, 16383, 1);
    add_random(150);
    drain();

    no_idle = 1'b1;
    load_regs(1000, 20070, 231367, 10000);
    add_random(150);
    drain();
    no_idle = 1'b0;

    // long receiver hold-off while the sender keeps offering
    load_regs($urandom_range(1000, 3000), $urandom_range(0, 1048575),
              $urandom_range(0, 16777215), $urandom_range(0, 10000));
    add_random(200);
    repeat (50) @(posedge clk);
    stall_kick <= 1'b1;
    @(posedge clk);
    stall_kick <= 1'b0;
    drain();

    load_regs(3000, $urandom_range(0, 1048575), $urandom_range(0, 16777215), 500);
    add_random(200);
    drain();

    load_regs(2127, 20070, 231367, 0);
    add_random(150);
    drain();

    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
